// ----- hw/rtl/pixel_blit_blend_macros.svh -----
// Assertion macros used by the checker file of the pixel blitter.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef PIXEL_BLIT_BLEND_MACROS_SVH
`define PIXEL_BLIT_BLEND_MACROS_SVH

// Antecedent true implies consequent in the same cycle.
`define PBB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent true implies consequent in the next cycle.
`define PBB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pbb_pkg.sv -----
// Types, codes and small helper functions of the pixel blitter.
// No dependencies; imported by pixel_blit_blend and pbb_checker.
package pbb_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SRC_FMT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DST_FMT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_EN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_VAL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SURF_ALP = 3'd4;

	// Commands
	localparam logic CMD_BLIT   = 1'b0;
	localparam logic CMD_PAL_WR = 1'b1;

	// Pixel formats
	localparam logic [1:0] FMT_IDX8   = 2'd0;
	localparam logic [1:0] FMT_RGB565 = 2'd1;
	localparam logic [1:0] FMT_XRGB   = 2'd2;
	localparam logic [1:0] FMT_ARGB   = 2'd3;

	// Outcome class of a blit beat, settled at entry except for zero alpha
	localparam logic [1:0] CLS_COPY  = 2'd0;
	localparam logic [1:0] CLS_SKIP  = 2'd1;
	localparam logic [1:0] CLS_BLEND = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic        command;
		logic [31:0] source_pixel;
		logic [31:0] under_pixel;
		logic [7:0]  entry_index;
		logic [7:0]  entry_red;
		logic [7:0]  entry_green;
		logic [7:0]  entry_blue;
	} pbb_in_t;

	typedef struct packed {
		logic        write_enable;
		logic [31:0] pixel_out;
	} pbb_out_t;

	// Keep only the bits that the format's depth uses
	function automatic logic [31:0] pix_mask(input logic [1:0] fmt, input logic [31:0] v);
		case (fmt)
			FMT_IDX8:   pix_mask = {24'd0, v[7:0]};
			FMT_RGB565: pix_mask = {16'd0, v[15:0]};
			default:    pix_mask = v;
		endcase
	endfunction

	// 0: one byte, 1: two bytes, 2: four bytes
	function automatic logic [1:0] depth_code(input logic [1:0] fmt);
		case (fmt)
			FMT_IDX8:   depth_code = 2'd0;
			FMT_RGB565: depth_code = 2'd1;
			default:    depth_code = 2'd2;
		endcase
	endfunction

	// RGB565 to RGB888 by bit replication
	function automatic logic [23:0] expand565(input logic [15:0] v);
		expand565 = {v[15:11], v[15:13], v[10:5], v[10:9], v[4:0], v[4:2]};
	endfunction

	// Exact floor(x / 255) for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
		div255 = t[15:8];
	endfunction

endpackage

// ----- hw/rtl/pbb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbb_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/pixel_blit_blend.sv -----
// Top level of the pixel blitter: five-stage blend pipeline and palette.
// Depends on pbb_pkg and pbb_ram.
//
// Usage:
//   req channel (req_valid/req_ready/req): one beat per pixel or palette write.
//     A blit beat carries the raw source pixel and the current destination
//     pixel; a palette-write beat stores one RGB entry and yields no result.
//   rsp channel (rsp_valid/rsp_ready/rsp): one beat per blit beat, in order,
//     with the write enable and the pixel in destination format.
//   cfg port: write cfg_data to register cfg_index while cfg_wr_en is high;
//     change registers only while no blit is in flight.
// Timing: a blit beat accepted on req passes through five register stages
//   (palette read, widen and alpha product, alpha divide, channel products,
//   channel divide and format narrowing) before it shows on rsp.
//   Throughput: one beat per cycle while the receiver does not stall.
// The palette is read at the accept edge, so a blit right after a palette
// write sees the new entry.
// Reset restores the register defaults, empties the pipeline and marks every
// palette entry unwritten (reads as black) at once; req_ready comes up with it.
// When the receiver stalls, the output beat holds; earlier stages keep
// filling empty slots, and req_ready falls once every stage is full.
module pixel_blit_blend
	import pbb_pkg::*;
#(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  pbb_in_t               req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output pbb_out_t              rsp
);

	localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [1:0]  src_fmt_q;
	logic [1:0]  dst_fmt_q;
	logic        key_en_q;
	logic [31:0] key_val_q;
	logic [7:0]  surf_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q    <= FMT_XRGB;
			dst_fmt_q    <= FMT_XRGB;
			key_en_q     <= 1'b0;
			key_val_q    <= '0;
			surf_alpha_q <= ALPHA_OPAQUE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SRC_FMT:  src_fmt_q    <= cfg_data[1:0];
				REG_DST_FMT:  dst_fmt_q    <= cfg_data[1:0];
				REG_KEY_EN:   key_en_q     <= cfg_data[0];
				REG_KEY_VAL:  key_val_q    <= cfg_data[31:0];
				REG_SURF_ALP: surf_alpha_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Pipeline flow control: a stage advances when it is empty or the next
	// stage advances, so bubbles squeeze out behind a stalled output.
	// ---------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5 = !vld_s5 || rsp_ready;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign req_ready = adv1;

	logic acc, blit_acc;
	assign acc      = req_valid && req_ready;
	assign blit_acc = acc && (req.command == CMD_BLIT);

	// ---------------------------------------------------------------------
	// Stage 0 (entry): mask raw values, classify the beat, index the palette
	// ---------------------------------------------------------------------
	logic [31:0]   raw0, und0;
	logic          copy0, key0, ii0;
	logic [1:0]    cls0;
	logic          sidx_ok0, uidx_ok0, widx_ok0;
	logic          sok0, uok0;
	logic [AW-1:0] sidx0, uidx0, widx0;
	logic          pal_we;

	assign raw0 = pix_mask(src_fmt_q, req.source_pixel);
	assign und0 = pix_mask(dst_fmt_q, req.under_pixel);

	// Same depth, no key, full surface alpha, no source alpha: plain copy
	assign copy0 = (depth_code(src_fmt_q) == depth_code(dst_fmt_q)) && !key_en_q
		&& (surf_alpha_q == ALPHA_OPAQUE) && (src_fmt_q != FMT_ARGB);
	assign key0  = key_en_q && (raw0 == key_val_q);
	assign ii0   = (src_fmt_q == FMT_IDX8) && (dst_fmt_q == FMT_IDX8);

	always_comb begin
		if (copy0) begin
			cls0 = CLS_COPY;
		end else if (key0) begin
			cls0 = CLS_SKIP;
		end else if (ii0) begin
			// Indexed to indexed: copy the index unless surface alpha is zero
			cls0 = (surf_alpha_q != 8'd0) ? CLS_COPY : CLS_SKIP;
		end else begin
			cls0 = CLS_BLEND;
		end
	end

	// Indexes beyond the palette read as black and are never written
	assign sidx_ok0 = {1'b0, raw0[7:0]} < 9'(PALETTE_ENTRIES);
	assign uidx_ok0 = {1'b0, und0[7:0]} < 9'(PALETTE_ENTRIES);
	assign widx_ok0 = {1'b0, req.entry_index} < 9'(PALETTE_ENTRIES);
	assign sidx0    = raw0[AW-1:0];
	assign uidx0    = und0[AW-1:0];
	assign widx0    = req.entry_index[AW-1:0];

	assign pal_we = acc && (req.command == CMD_PAL_WR) && widx_ok0;

	// Written flags per entry; an unwritten entry reads as black
	logic [PALETTE_ENTRIES-1:0] pal_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (pal_we) begin
			pal_vld_q[widx0] <= 1'b1;
		end
	end

	assign sok0 = sidx_ok0 && pal_vld_q[sidx0];
	assign uok0 = uidx_ok0 && pal_vld_q[uidx0];

	// Two copies of the palette: one for the source index, one for the
	// destination index. Both take every write; read data forms stage 1.
	logic [23:0] pal_wdata;
	logic [23:0] src_pal_s1, und_pal_s1;

	assign pal_wdata = {req.entry_red, req.entry_green, req.entry_blue};

	pbb_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_ENTRIES)
	) u_pal_src (
		.clk   (clk),
		.we    (pal_we),
		.waddr (widx0),
		.wdata (pal_wdata),
		.re    (acc),
		.raddr (sidx0),
		.rdata (src_pal_s1)
	);

	pbb_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_ENTRIES)
	) u_pal_und (
		.clk   (clk),
		.we    (pal_we),
		.waddr (widx0),
		.wdata (pal_wdata),
		.re    (acc),
		.raddr (uidx0),
		.rdata (und_pal_s1)
	);

	// ---------------------------------------------------------------------
	// Stage 1 registers
	// ---------------------------------------------------------------------
	logic [1:0]  cls_s1;
	logic [31:0] raw_s1, und_s1;
	logic        sok_s1, uok_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			cls_s1 <= cls0;
			raw_s1 <= raw0;
			und_s1 <= und0;
			sok_s1 <= sok0;
			uok_s1 <= uok0;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: widen source and destination, form alpha product
	// ---------------------------------------------------------------------
	logic [31:0] sargb1;
	logic [23:0] urgb1;
	logic [15:0] prod1;

	always_comb begin
		case (src_fmt_q)
			FMT_IDX8:   sargb1 = {ALPHA_OPAQUE, sok_s1 ? src_pal_s1 : 24'd0};
			FMT_RGB565: sargb1 = {ALPHA_OPAQUE, expand565(raw_s1[15:0])};
			FMT_XRGB:   sargb1 = {ALPHA_OPAQUE, raw_s1[23:0]};
			default:    sargb1 = raw_s1;
		endcase
		case (dst_fmt_q)
			FMT_IDX8:   urgb1 = uok_s1 ? und_pal_s1 : 24'd0;
			FMT_RGB565: urgb1 = expand565(und_s1[15:0]);
			default:    urgb1 = und_s1[23:0];
		endcase
	end

	assign prod1 = {8'd0, sargb1[31:24]} * {8'd0, surf_alpha_q};

	logic [1:0]  cls_s2;
	logic [31:0] raw_s2;
	logic [23:0] srgb_s2, urgb_s2;
	logic [15:0] prod_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			cls_s2  <= cls_s1;
			raw_s2  <= raw_s1;
			srgb_s2 <= sargb1[23:0];
			urgb_s2 <= urgb1;
			prod_s2 <= prod1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: effective alpha; zero alpha drops the pixel
	// ---------------------------------------------------------------------
	logic [7:0] alpha2;
	assign alpha2 = div255(prod_s2);

	logic [1:0]  cls_s3;
	logic [31:0] raw_s3;
	logic [23:0] srgb_s3, urgb_s3;
	logic [7:0]  alpha_s3, inv_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			cls_s3   <= ((cls_s2 == CLS_BLEND) && (alpha2 == 8'd0)) ? CLS_SKIP : cls_s2;
			raw_s3   <= raw_s2;
			srgb_s3  <= srgb_s2;
			urgb_s3  <= urgb_s2;
			alpha_s3 <= alpha2;
			inv_s3   <= ALPHA_OPAQUE - alpha2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: per-channel weighted sums. Full alpha gives c * 255, which
	// divides back to c, so opaque pixels need no separate path.
	// ---------------------------------------------------------------------
	logic [2:0][15:0] sum3;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum3[c] = {8'd0, srgb_s3[8*c +: 8]} * {8'd0, alpha_s3}
				+ {8'd0, urgb_s3[8*c +: 8]} * {8'd0, inv_s3};
		end
	end

	logic [1:0]       cls_s4;
	logic [31:0]      raw_s4;
	logic [2:0][15:0] sum_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			cls_s4 <= cls_s3;
			raw_s4 <= raw_s3;
			sum_s4 <= sum3;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5 (output register): divide, narrow to destination, select
	// ---------------------------------------------------------------------
	logic [23:0] rgb4;
	logic [31:0] narrow4;
	pbb_out_t    res4;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rgb4[8*c +: 8] = div255(sum_s4[c]);
		end
		case (dst_fmt_q)
			FMT_IDX8:   narrow4 = {24'd0, rgb4[7:0]};
			FMT_RGB565: narrow4 = {16'd0, rgb4[23:19], rgb4[15:10], rgb4[7:3]};
			default:    narrow4 = {ALPHA_OPAQUE, rgb4};
		endcase
		case (cls_s4)
			CLS_COPY: begin
				res4.write_enable = 1'b1;
				res4.pixel_out    = raw_s4;
			end
			CLS_BLEND: begin
				res4.write_enable = 1'b1;
				res4.pixel_out    = narrow4;
			end
			default: begin
				res4.write_enable = 1'b0;
				res4.pixel_out    = '0;
			end
		endcase
	end

	pbb_out_t out_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			out_s5 <= res4;
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= blit_acc;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
			if (adv3) begin
				vld_s3 <= vld_s2;
			end
			if (adv4) begin
				vld_s4 <= vld_s3;
			end
			if (adv5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	assign rsp_valid = vld_s5;
	assign rsp       = out_s5;

endmodule

// ----- hw/rtl/pbb_checker.sv -----
// Port-level assertions for the pixel blitter, bound to the top level.
// Depends on pbb_pkg and pixel_blit_blend_macros.svh.
`include "pixel_blit_blend_macros.svh"

module pbb_checker
	import pbb_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_wr_en,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  req_valid,
	input logic                  req_ready,
	input pbb_in_t               req,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input pbb_out_t              rsp
);

	logic blit_beat;
	logic cfg_seen;
	assign blit_beat = req_valid && req_ready && (req.command == CMD_BLIT);
	assign cfg_seen  = cfg_wr_en && (cfg_index == REG_SRC_FMT) && (cfg_data == '0);

	// Stalled output beat holds
	`PBB_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

	// Skipped pixel carries a zero pixel
	`PBB_ASSERT_IMP(a_skip_zero, rsp_valid && !rsp.write_enable, rsp.pixel_out == 32'd0, "skipped pixel not zero")

	// Nothing comes out right after reset (not checked while cfg writes zero to REG_SRC_FMT)
	`PBB_ASSERT_IMP(a_rst_empty, !$past(arst_n) && !cfg_seen, !rsp_valid, "result right after reset")

	// An accepted blit beat shows on rsp when rsp_ready and arst_n stay high meanwhile
	`PBB_ASSERT_IMP(a_latency, $past(blit_beat, 5) && $past(rsp_ready, 1) && $past(rsp_ready, 2) && $past(rsp_ready, 3) && $past(rsp_ready, 4) && $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) && $past(arst_n, 4) && $past(arst_n, 5), rsp_valid, "blit result late")

endmodule

bind pixel_blit_blend pbb_checker u_pbb_checker (.*);
